[rtl/slle_pkg.sv]
// Shared types and codes for the singly linked list engine.
// Depends on nothing; the top level and the allocator import it.
package slle_pkg;

	// Result fields are fixed by the port definition
	localparam int FIELD_W    = 32;
	localparam int EXT_W      = 64;
	// Widest node index, for the largest supported pool
	localparam int SLOT_MAX_W = 11;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_DELETE     = 2'd2,
		REQ_READ_OUT   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_LINK_TAIL,
		S_DEL_WALK,
		S_RD_WALK,
		S_RESP
	} state_t;

	// Sequencer to allocator
	typedef struct packed {
		logic                  scan;
		logic                  release_en;
		logic [SLOT_MAX_W-1:0] rel_slot;
	} alloc_req_t;

	// Allocator to sequencer
	typedef struct packed {
		logic                  found;
		logic [SLOT_MAX_W-1:0] slot;
	} alloc_rsp_t;

endpackage

[rtl/singly_linked_list_engine.sv]
// Top level of the singly linked list engine: request sequencer, node memories, result register.
// Depends on slle_pkg, slle_ram and slle_alloc.
//
// The engine keeps a list of up to CAPACITY nodes in two one-port-read RAMs (node values and
// next links) and handles one request at a time. Insert at front or back takes the lowest free
// node, searching the free flags in groups of up to 16 nodes, and an insert at the back of a
// non-empty list then writes the old tail's link separately. Delete walks from the head through
// the link memory, one node per cycle, until the first match or the last node. Read-out streams
// one value per cycle from head to tail and pauses whenever the result side stalls. The walk
// through the link RAM makes one registered read per node. A final result can wait in the
// output register while the next request is already taken in. Node RAMs need no clearing after
// reset: walks only ever follow links that were written.
module singly_linked_list_engine
	import slle_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic signed [FIELD_W-1:0]         value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [FIELD_W-1:0]         item_value,
	output logic [$clog2(CAPACITY+1)-1:0]     entry_total,
	output logic                              last_result
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// sequencer state and list bookkeeping
	state_t                state_q, state_d;
	req_t                  req_q;
	status_t               st_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      n_q;
	logic [IDX_W-1:0]      head_q, tail_q, cur_q, prev_q, slot_q;

	// result register
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [FIELD_W-1:0]    out_item_q;
	logic [CNT_W-1:0]      out_total_q;
	logic                  out_last_q;

	// memory ports
	logic                  rd_re;
	logic [IDX_W-1:0]      rd_addr;
	logic [DATA_WIDTH-1:0] val_rd;
	logic [IDX_W-1:0]      link_rd;
	logic                  val_we;
	logic [IDX_W-1:0]      val_waddr;
	logic                  link_we;
	logic [IDX_W-1:0]      link_waddr;
	logic [IDX_W-1:0]      link_wdata;

	alloc_req_t            alloc_req;
	alloc_rsp_t            alloc_rsp;
	logic [IDX_W-1:0]      new_slot;

	// decoded conditions
	req_t                  req_in;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  match;
	logic                  walk_last;
	logic                  out_free;
	logic                  out_load;
	status_t               out_status_d;
	logic [FIELD_W-1:0]    out_item_d;
	logic                  out_last_d;

	logic signed [EXT_W-1:0] value_ext;
	logic [DATA_WIDTH-1:0]   data_in;
	logic [EXT_W-1:0]        val_ext;

	// Sign-extend the request value, then keep DATA_WIDTH bits of it
	assign value_ext = EXT_W'(value);
	assign data_in   = value_ext[DATA_WIDTH-1:0];
	// Stored value back to the 32-bit result field, sign-extended from DATA_WIDTH
	assign val_ext   = EXT_W'($signed(val_rd));

	assign req_in    = req_t'(req_type);
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign match     = (val_rd == data_q);
	assign walk_last = ((n_q + CNT_W'(1)) == cnt_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign new_slot  = alloc_rsp.slot[IDX_W-1:0];

	slle_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_value_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(data_q),
		.re   (rd_re),
		.raddr(rd_addr),
		.rdata(val_rd)
	);

	slle_ram #(
		.WIDTH(IDX_W),
		.DEPTH(CAPACITY)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (rd_re),
		.raddr(rd_addr),
		.rdata(link_rd)
	);

	slle_alloc #(
		.CAPACITY(CAPACITY)
	) u_alloc (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alloc_req),
		.rsp   (alloc_rsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (req_in)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: state_d = full  ? S_RESP : S_ALLOC;
						REQ_DELETE:                    state_d = empty ? S_RESP : S_DEL_WALK;
						REQ_READ_OUT:                  state_d = empty ? S_RESP : S_RD_WALK;
						default:                       state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC: begin
				if (alloc_rsp.found) begin
					state_d = (req_q == REQ_PUSH_BACK && !empty) ? S_LINK_TAIL : S_RESP;
				end
			end
			S_LINK_TAIL: state_d = S_RESP;
			S_DEL_WALK: begin
				if (match || walk_last) begin
					state_d = S_RESP;
				end
			end
			S_RD_WALK: begin
				if (out_free && walk_last) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory, allocator and result controls
	always_comb begin
		rd_re                = 1'b0;
		rd_addr              = head_q;
		val_we               = 1'b0;
		val_waddr            = new_slot;
		link_we              = 1'b0;
		link_waddr           = new_slot;
		link_wdata           = '0;
		alloc_req.scan       = 1'b0;
		alloc_req.release_en = 1'b0;
		alloc_req.rel_slot   = SLOT_MAX_W'(cur_q);
		out_load             = 1'b0;
		out_status_d         = st_q;
		out_item_d           = '0;
		out_last_d           = 1'b1;
		case (state_q)
			S_IDLE: begin
				// open a walk at the head
				if (accept && !empty && (req_in == REQ_DELETE || req_in == REQ_READ_OUT)) begin
					rd_re = 1'b1;
				end
			end
			S_ALLOC: begin
				alloc_req.scan = 1'b1;
				if (alloc_rsp.found) begin
					val_we  = 1'b1;
					link_we = 1'b1;
					// front insert points at the old head, others end the list
					if (req_q == REQ_PUSH_FRONT && !empty) begin
						link_wdata = head_q;
					end
				end
			end
			S_LINK_TAIL: begin
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = slot_q;
			end
			S_DEL_WALK: begin
				if (match) begin
					alloc_req.release_en = 1'b1;
					// unlink from the previous node unless the match is the head
					if (n_q != '0) begin
						link_we    = 1'b1;
						link_waddr = prev_q;
						link_wdata = link_rd;
					end
				end else if (!walk_last) begin
					rd_re   = 1'b1;
					rd_addr = link_rd;
				end
			end
			S_RD_WALK: begin
				out_status_d = STAT_OK;
				out_item_d   = val_ext[FIELD_W-1:0];
				out_last_d   = walk_last;
				if (out_free) begin
					out_load = 1'b1;
					if (!walk_last) begin
						rd_re   = 1'b1;
						rd_addr = link_rd;
					end
				end
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Sequencer registers and list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_ALLOC: begin
					if (alloc_rsp.found) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (empty) begin
							head_q <= new_slot;
							tail_q <= new_slot;
						end else if (req_q == REQ_PUSH_FRONT) begin
							head_q <= new_slot;
						end
					end
				end
				S_LINK_TAIL: begin
					tail_q <= slot_q;
				end
				S_DEL_WALK: begin
					if (match) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (n_q == '0) begin
							head_q <= link_rd;
						end else if (cur_q == tail_q) begin
							// deleting the tail: the tail moves back one node
							tail_q <= prev_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q  <= req_in;
					data_q <= data_in;
					n_q    <= '0;
					cur_q  <= head_q;
					prev_q <= head_q;
					case (req_in)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: st_q <= STAT_FULL;
						REQ_DELETE:                    st_q <= STAT_NOT_FOUND;
						REQ_READ_OUT:                  st_q <= STAT_EMPTY;
						default:                       st_q <= STAT_OK;
					endcase
				end
			end
			S_ALLOC: begin
				if (alloc_rsp.found) begin
					slot_q <= new_slot;
					st_q   <= STAT_OK;
				end
			end
			S_DEL_WALK: begin
				if (match) begin
					st_q <= STAT_OK;
				end else if (!walk_last) begin
					// advance one node
					prev_q <= cur_q;
					cur_q  <= link_rd;
					n_q    <= n_q + CNT_W'(1);
				end
			end
			S_RD_WALK: begin
				if (out_free && !walk_last) begin
					n_q <= n_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Result register: load when empty or when the waiting transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_item_q   <= out_item_d;
			out_total_q  <= cnt_q;
			out_last_q   <= out_last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign item_value  = out_item_q;
	assign entry_total = out_total_q;
	assign last_result = out_last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above pool size");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_WALK || state_q == S_DEL_WALK) |-> !empty)
		else $error("list walk on an empty list");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten before transfer");

	a_tail_link_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK_TAIL |=> state_q == S_RESP && tail_q == $past(slot_q))
		else $error("tail not advanced after back insert");
`endif

endmodule

[rtl/slle_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/slle_alloc.sv]
// Free-node tracker: one flag per node, lowest-free search over chunks of nodes.
// Depends on slle_pkg for the request and response structs.
module slle_alloc
	import slle_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  alloc_req_t req,
	output alloc_rsp_t rsp
);

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CHUNK_W = (CAPACITY < 16) ? CAPACITY : 16;
	localparam int NCHUNK  = (CAPACITY + CHUNK_W - 1) / CHUNK_W;
	localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int ENC_W   = $clog2(CHUNK_W);

	logic [CAPACITY-1:0] free_q;
	logic [CH_W-1:0]     ch_q;
	logic [CHUNK_W-1:0]  chunk;
	logic [ENC_W-1:0]    enc;
	logic                found;
	logic [IDX_W-1:0]    slot_idx;
	logic [IDX_W-1:0]    rel_idx;

	// gather the current chunk; nodes past the pool end read as taken
	always_comb begin
		int base;
		base = int'(ch_q) * CHUNK_W;
		for (int b = 0; b < CHUNK_W; b++) begin
			chunk[b] = ((base + b) < CAPACITY) ? free_q[IDX_W'(base + b)] : 1'b0;
		end
	end

	// lowest set bit of the chunk
	always_comb begin
		enc = '0;
		for (int b = CHUNK_W - 1; b >= 0; b--) begin
			if (chunk[b]) begin
				enc = ENC_W'(b);
			end
		end
	end

	assign found    = |chunk;
	assign slot_idx = IDX_W'(int'(ch_q) * CHUNK_W + int'(enc));
	assign rel_idx  = req.rel_slot[IDX_W-1:0];

	assign rsp.found = req.scan && found;
	assign rsp.slot  = SLOT_MAX_W'(slot_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			ch_q   <= '0;
		end else begin
			if (req.scan) begin
				if (found) begin
					// claim the node and restart the next search at chunk zero
					free_q[slot_idx] <= 1'b0;
					ch_q             <= '0;
				end else begin
					ch_q <= ch_q + CH_W'(1);
				end
			end else begin
				ch_q <= '0;
			end
			if (req.release_en) begin
				free_q[rel_idx] <= 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_scan_release: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.scan && req.release_en))
		else $error("allocation and release in the same cycle");

	a_release_taken: assert property (@(posedge clk) disable iff (!arst_n)
		req.release_en |-> !free_q[rel_idx])
		else $error("release of a node that is already free");

	a_claim_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req.scan && found) |=> !free_q[$past(slot_idx)])
		else $error("claimed node still marked free");
`endif

endmodule
